@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CCH_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CCH_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/cch_pkg.sv @@
`default_nettype none

package cch_pkg;

    localparam int WORDS        = 32;
    localparam int HALF         = 16;
    localparam int WORD_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int BITCNT_W     = 4;
    localparam int BYTE_IDX_W   = 5;
    localparam int DIGEST_BYTES = 16;
    localparam int DIG_CNT_W    = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int ROT_A        = 7;
    localparam int ROT_B        = 11;

    localparam logic [BITCNT_W-1:0] BITS_FULL = 4'd8;
    localparam logic [BYTE_W-1:0]   PAD_BYTE  = 8'h80;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [WORDS-1:0][WORD_W-1:0] chain_t;

    localparam word_t IV_W0 = word_t'(128 / 8);
    localparam word_t IV_W1 = word_t'(32);
    localparam word_t IV_W2 = word_t'(16);

    typedef enum logic [1:0] {
        CMD_ABSORB,
        CMD_LAST_FULL,
        CMD_LAST_PART
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XFORM,
        ST_PAD,
        ST_FLIP,
        ST_XF2,
        ST_DIGEST
    } back_state_t;

    function automatic word_t rotl(word_t a, int n);
        return (a << n) | (a >> (WORD_W - n));
    endfunction

    function automatic chain_t iv_raw();
        chain_t v;
        v    = '0;
        v[0] = IV_W0;
        v[1] = IV_W1;
        v[2] = IV_W2;
        return v;
    endfunction

    // phase 0: add, swap 8, rotate 7, xor, swap 2
    // phase 1: add, swap 4, rotate 11, xor, swap 1
    function automatic chain_t half_round(chain_t x, logic phase);
        chain_t                y;
        word_t [HALF-1:0]      u;
        for (int i = 0; i < HALF; i++)
        begin
            u[i] = x[i + HALF] + x[i];
        end
        for (int i = 0; i < HALF; i++)
        begin
            y[i] = (phase ? rotl(x[i ^ 4], ROT_B) : rotl(x[i ^ 8], ROT_A)) ^ u[i];
            y[i + HALF] = phase ? u[i ^ 1] : u[i ^ 2];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

@@ design/cch_msg_if.sv @@
`default_nettype none

interface cch_msg_if import cch_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   msg_byte;
    logic [BITCNT_W-1:0] bit_count;
    logic                msg_last;

    modport source (output valid, output msg_byte, output bit_count, output msg_last,
                    input ready);
    modport sink   (input valid, input msg_byte, input bit_count, input msg_last,
                    output ready);
endinterface

`default_nettype wire

@@ design/cch_digest_if.sv @@
`default_nettype none

interface cch_digest_if import cch_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] digest_byte;
    logic              digest_last;

    modport source (output valid, output digest_byte, output digest_last, input ready);
    modport sink   (input valid, input digest_byte, input digest_last, output ready);
endinterface

`default_nettype wire

@@ design/cch_front.sv @@
`default_nettype none

module cch_front import cch_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    cch_msg_if.sink   msg,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_reg;
    cmd_t hold_next;
    logic take;
    logic [2:0] sat;

    assign msg.ready = !hold_valid_reg || out_ready;
    assign take      = msg.valid && msg.ready;
    assign sat       = msg.bit_count[2:0];

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (out_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (take)
        begin
            hold_valid_next = 1'b1;
            if (!msg.msg_last)
            begin
                hold_next.kind = CMD_ABSORB;
                hold_next.data = msg.msg_byte;
            end
            else if (msg.bit_count >= BITS_FULL)
            begin
                hold_next.kind = CMD_LAST_FULL;
                hold_next.data = msg.msg_byte;
            end
            else
            begin
                // keep the valid top bits, pad right behind them
                hold_next.kind = CMD_LAST_PART;
                hold_next.data = (msg.msg_byte & ~(8'hFF >> sat)) | (PAD_BYTE >> sat);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign out_valid = hold_valid_reg;
    assign out_cmd   = hold_reg;

endmodule

`default_nettype wire

@@ design/cch_queue.sv @@
`default_nettype none
`include "assert_macros.svh"

module cch_queue import cch_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign in_ready  = cnt_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_cmd   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

    `CCH_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `CCH_ASSERT_NXT(a_push_grows, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "push lost")

endmodule

`default_nettype wire

@@ design/cch_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module cch_back import cch_pkg::*; #(
    parameter int ROUNDS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cmd_valid,
    output logic         cmd_ready,
    input  wire cmd_t    cmd,
    cch_digest_if.source digest
);

    localparam int STEPS  = 2 * ROUNDS;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
    localparam logic [BYTE_IDX_W-1:0] IDX_LAST = BYTE_IDX_W'(WORDS - 1);
    localparam logic [DIG_CNT_W-1:0] DIG_FULL = DIG_CNT_W'(DIGEST_BYTES);

    back_state_t                  state_reg;
    back_state_t                  state_next;
    back_state_t                  ret_reg;
    back_state_t                  ret_next;
    logic [STEP_W-1:0]            step_reg;
    logic [STEP_W-1:0]            step_next;
    logic [BYTE_IDX_W-1:0]        idx_reg;
    logic [BYTE_IDX_W-1:0]        idx_next;
    chain_t                       words_reg;
    chain_t                       words_next;
    logic [DIGEST_BYTES*BYTE_W-1:0] dig_reg;
    logic [DIGEST_BYTES*BYTE_W-1:0] dig_next;
    logic [DIG_CNT_W-1:0]         dig_cnt_reg;
    logic [DIG_CNT_W-1:0]         dig_cnt_next;
    logic                         ins_en;
    logic [BYTE_W-1:0]            ins_data;
    logic [BYTE_IDX_W-1:0]        wsel;
    logic                         dig_load;
    logic                         dig_loaded;

    assign wsel = {2'b00, idx_reg[4:2]};

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        words_next   = words_reg;
        dig_next     = dig_reg;
        dig_cnt_next = dig_cnt_reg;
        cmd_ready    = 1'b0;
        ins_en       = 1'b0;
        ins_data     = '0;

        if (digest.valid && digest.ready)
        begin
            dig_next     = dig_reg >> BYTE_W;
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_ready = 1'b1;
                    ins_en    = 1'b1;
                    ins_data  = cmd.data;
                    unique case (cmd.kind)
                        CMD_ABSORB:
                        begin
                            idx_next = idx_reg + 1'b1;
                            if (idx_reg == IDX_LAST)
                            begin
                                state_next = ST_XFORM;
                                ret_next   = ST_IDLE;
                            end
                        end
                        CMD_LAST_FULL:
                        begin
                            idx_next = idx_reg + 1'b1;
                            if (idx_reg == IDX_LAST)
                            begin
                                state_next = ST_XFORM;
                                ret_next   = ST_PAD;
                            end
                            else
                            begin
                                state_next = ST_PAD;
                            end
                        end
                        CMD_LAST_PART:
                        begin
                            state_next = ST_XFORM;
                            ret_next   = ST_FLIP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAD:
            begin
                ins_en     = 1'b1;
                ins_data   = PAD_BYTE;
                state_next = ST_XFORM;
                ret_next   = ST_FLIP;
            end
            ST_XFORM:
            begin
                words_next = half_round(words_reg, step_reg[0]);
                step_next  = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = ret_reg;
                end
            end
            ST_FLIP:
            begin
                words_next[WORDS-1][0] = ~words_reg[WORDS-1][0];
                state_next = ST_XFORM;
                ret_next   = ST_XF2;
            end
            ST_XF2:
            begin
                state_next = ST_XFORM;
                ret_next   = ST_DIGEST;
            end
            ST_DIGEST:
            begin
                // hand the digest to the output buffer, then rebuild the IV
                if (dig_cnt_reg == '0)
                begin
                    dig_next     = words_reg[3:0];
                    dig_cnt_next = DIG_FULL;
                    words_next   = iv_raw();
                    idx_next     = '0;
                    state_next   = ST_XFORM;
                    ret_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ins_en)
        begin
            words_next[wsel] = words_reg[wsel]
                             ^ (word_t'(ins_data) << {idx_reg[1:0], 3'b000});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_XFORM;
            ret_reg     <= ST_IDLE;
            step_reg    <= '0;
            idx_reg     <= '0;
            dig_cnt_reg <= '0;
            words_reg   <= iv_raw();
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            step_reg    <= step_next;
            idx_reg     <= idx_next;
            dig_cnt_reg <= dig_cnt_next;
            words_reg   <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

    assign digest.valid       = dig_cnt_reg != '0;
    assign digest.digest_byte = dig_reg[BYTE_W-1:0];
    assign digest.digest_last = dig_cnt_reg == DIG_CNT_W'(1);

    assign dig_load   = state_reg == ST_DIGEST && dig_cnt_reg == '0;
    assign dig_loaded = dig_cnt_reg == DIG_FULL && state_reg == ST_XFORM;

    `CCH_ASSERT_IMP(a_dig_cnt_range, 1'b1, dig_cnt_reg <= DIG_FULL, "digest count overflow")
    `CCH_ASSERT_NXT(a_dig_load, dig_load, dig_loaded, "digest not loaded")
    `CCH_ASSERT_IMP(a_step_idle, state_reg != ST_XFORM, step_reg == '0, "round step left dirty")

endmodule

`default_nettype wire

@@ design/cubehash_128_byte_stream.sv @@
// CubeHash with 32-byte blocks and a 128-bit digest over a byte stream. Message
// words go through a one-stage classifier and a two-entry queue into the hash
// core, which applies one byte per cycle while it is idle (not in a transform)
// and runs each transform on one shared half-round unit. The last word starts
// finalization: absorb and padding (with one more transform between them when
// the last byte fills a block), three transforms with a flip state and a plain
// control state between them, then the digest state moves the digest into its
// output buffer once that buffer is empty. The 16 digest bytes leave at one per
// cycle from that buffer while the consumer is ready, as the core rebuilds the IV
// in one further transform; the next message can then be absorbed while the
// digest still drains. After reset the core builds the IV in one transform;
// input words are queued meanwhile.
`default_nettype none

module cubehash_128_byte_stream import cch_pkg::*; #(
    parameter int ROUNDS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cch_msg_if.sink      msg,
    cch_digest_if.source digest
);

    logic fr_valid;
    logic fr_ready;
    cmd_t fr_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    cch_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_cmd   (fr_cmd)
    );

    cch_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cmd    (fr_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    cch_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .digest    (digest)
    );

endmodule

`default_nettype wire

@@ test/cubehash_digest_checker.sv @@
module cubehash_digest_checker
    import cch_pkg::*;
#(
    parameter int ROUNDS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    cch_msg_if    msg,
    cch_digest_if digest,
    output int    fail_count,
    output int    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              tail;
    } digest_word_t;

    chain_t       chain;
    chain_t       iv_chain;
    logic [8:0]   bitpos;
    digest_word_t pending_digest[$];

    function automatic word_t rol(word_t w, int n);
        logic [2*WORD_W-1:0] twice;
        twice = {w, w} << n;
        return twice[2*WORD_W-1 -: WORD_W];
    endfunction

    function automatic chain_t mix_half(chain_t s, int lo_swap, int rot, int hi_swap);
        word_t [HALF-1:0] t;
        for (int i = 0; i < HALF; i++)
            s[i + HALF] += s[i];
        for (int i = 0; i < HALF; i++)
            t[i ^ lo_swap] = s[i];
        for (int i = 0; i < HALF; i++)
            s[i] = rol(t[i], rot) ^ s[i + HALF];
        for (int i = 0; i < HALF; i++)
            t[i ^ hi_swap] = s[i + HALF];
        for (int i = 0; i < HALF; i++)
            s[i + HALF] = t[i];
        return s;
    endfunction

    function automatic chain_t mix_rounds(chain_t s);
        for (int r = 0; r < ROUNDS; r++)
        begin
            s = mix_half(s, 8, ROT_A, 2);
            s = mix_half(s, 4, ROT_B, 1);
        end
        return s;
    endfunction

    function automatic void stir(logic [BYTE_W-1:0] b);
        chain[bitpos[7:5]] ^= word_t'(b) << (BYTE_W * bitpos[4:3]);
    endfunction

    function automatic void take_byte(logic [BYTE_W-1:0] b);
        stir(b);
        bitpos += 9'd8;
        if (bitpos >= 9'd256)
        begin
            chain  = mix_rounds(chain);
            bitpos = '0;
        end
    endfunction

    function automatic void predict_word(logic [BYTE_W-1:0] b, logic [BITCNT_W-1:0] nbits,
                                         logic fin);
        logic [BITCNT_W-1:0] used;
        logic [BYTE_W-1:0]   kept;
        word_t               w;
        bitpos[2:0] = '0;
        if (!fin)
        begin
            take_byte(b);
            return;
        end
        used = (nbits > BITS_FULL) ? BITS_FULL : nbits;
        if (used == BITS_FULL)
        begin
            take_byte(b);
            stir(PAD_BYTE);
        end
        else
        begin
            kept = b & (8'hFF << (BYTE_W - used));
            stir(kept | (PAD_BYTE >> used));
        end
        chain = mix_rounds(chain);
        chain[WORDS-1] ^= word_t'(1);
        chain = mix_rounds(mix_rounds(chain));
        for (int i = 0; i < DIGEST_BYTES; i++)
        begin
            w = chain[i / 4];
            pending_digest.push_back('{value: w[8*(i%4) +: 8], tail: (i == DIGEST_BYTES - 1)});
        end
        chain  = iv_chain;
        bitpos = '0;
    endfunction

    task automatic report_mismatch(input string text);
        $display("%0t mismatch: %s", $time, text);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t want;
        if (!rst_n)
        begin
            iv_chain    = '0;
            iv_chain[0] = IV_W0;
            iv_chain[1] = IV_W1;
            iv_chain[2] = IV_W2;
            iv_chain    = mix_rounds(iv_chain);
            chain       = iv_chain;
            bitpos      = '0;
            pending_digest.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (digest.valid && digest.ready)
            begin
                if (pending_digest.size() == 0)
                    report_mismatch($sformatf("digest word 0x%02h with nothing pending",
                                              digest.digest_byte));
                else
                begin
                    want = pending_digest.pop_front();
                    if (digest.digest_byte !== want.value)
                        report_mismatch($sformatf("digest_byte 0x%02h, predicted 0x%02h",
                                                  digest.digest_byte, want.value));
                    if (digest.digest_last !== want.tail)
                        report_mismatch($sformatf("digest_last %b, predicted %b",
                                                  digest.digest_last, want.tail));
                end
            end
            if (msg.valid && msg.ready)
                predict_word(msg.msg_byte, msg.bit_count, msg.msg_last);
            outstanding = pending_digest.size();
        end
    end
endmodule

@@ test/cubehash_128_byte_stream_tb.sv @@
module cubehash_128_byte_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cch_pkg::*;

    localparam int ROUNDS      = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 300;
    localparam int RANDOM_WORDS = 90;

    logic clk;
    logic rst_n;
    bit   tx_calm;
    bit   rx_calm;
    bit   rx_hold;
    bit   hold_start;
    int   fail_count;
    int   pending_count;
    int   cycle_count;

    cch_msg_if    msg();
    cch_digest_if digest();

    cubehash_128_byte_stream #(.ROUNDS(ROUNDS)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .digest (digest)
    );

    cubehash_digest_checker #(.ROUNDS(ROUNDS)) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg         (msg),
        .digest      (digest),
        .fail_count  (fail_count),
        .outstanding (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        digest.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold)
                digest.ready <= 1'b0;
            else
                digest.ready <= rx_calm || ($urandom_range(99) >= 22);
        end
    end

    // hold the digest side off so the block backs up into its input
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_start);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic send_word(input logic [BYTE_W-1:0] value, input logic [BITCNT_W-1:0] nbits,
                             input logic tail);
        while (!tx_calm && $urandom_range(99) < 22)
        begin
            msg.valid <= 1'b0;
            @(posedge clk);
        end
        msg.valid     <= 1'b1;
        msg.msg_byte  <= value;
        msg.bit_count <= nbits;
        msg.msg_last  <= tail;
        @(posedge clk);
        while (!msg.ready)
            @(posedge clk);
    endtask

    task automatic send_message(input int body_len, input logic [BITCNT_W-1:0] tail_bits);
        for (int k = 0; k < body_len; k++)
            send_word(8'($urandom), 4'($urandom), 1'b0);
        send_word(8'($urandom), tail_bits, 1'b1);
    endtask

    initial
    begin
        int                  body_len;
        int                  sent_random;
        int                  msg_index;
        logic [BITCNT_W-1:0] tail_bits;
        rst_n         <= 1'b0;
        msg.valid     <= 1'b0;
        msg.msg_byte  <= '0;
        msg.bit_count <= '0;
        msg.msg_last  <= 1'b0;
        tx_calm        = 1'b0;
        rx_calm       <= 1'b0;
        hold_start    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // one-word messages across every bit_count, including saturation
        for (int n = 0; n < 16; n++)
            send_word(n[0] ? 8'h00 : 8'hFF, BITCNT_W'(n), 1'b1);
        send_word(8'h00, 4'd15, 1'b0);
        send_word(8'hFF, 4'd0, 1'b0);
        send_word(8'h80, 4'd1, 1'b1);
        send_word(8'hFF, BITS_FULL, 1'b0);
        send_word(8'h01, 4'd7, 1'b1);

        sent_random = 0;
        msg_index   = 0;
        while (sent_random < RANDOM_WORDS || msg_index < 5)
        begin
            tx_calm  = (msg_index <= 2);
            rx_calm <= (msg_index <= 2);
            if (msg_index == 3)
                hold_start <= 1'b1;
            tail_bits = 4'($urandom_range(15));
            if (msg_index == 0)
            begin
                body_len  = 31;
                tail_bits = BITS_FULL;
            end
            else
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        body_len = 31;
                        if ($urandom_range(1))
                            tail_bits = BITS_FULL;
                    end
                    1: body_len = $urandom_range(3);
                    2: body_len = $urandom_range(40);
                    default: body_len = $urandom_range(15);
                endcase
            end
            send_message(body_len, tail_bits);
            sent_random += body_len + 1;
            msg_index++;
        end
        msg.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
